@@ hdl/fpd_pkg.sv @@
// Package with types, constants and the reciprocal seed table of the fixed-point divider.
`default_nettype none
package fpd_pkg;

    localparam int DataWidth  = 32;
    localparam int TdataWidth = 64;
    localparam int NStages    = 8;
    localparam logic [31:0] SatNeg = 32'h8000_0000;
    localparam logic [31:0] SatPos = 32'h7fff_ffff;

    typedef logic [31:0] word_t;

    // Payload that travels down the pipeline.
    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [4:0]  sh;
        word_t       d;
        word_t       n1;
        word_t       n0;
        word_t       v;
        word_t       a;
        word_t       b;
        word_t       c;
    } stage_t;

    // 512-entry table of 15-bit reciprocal seeds, indexed by the divisor's bits 30:22.
    function automatic logic [15:0] seed_lookup(input logic [8:0] idx);
        logic [15:0] tab [0:511];
        tab = '{
 16'h7fe1,16'h7fa1,16'h7f61,16'h7f22,16'h7ee3,16'h7ea4,16'h7e65,16'h7e27,16'h7de9,16'h7dab,16'h7d6d,16'h7d30,16'h7cf3,16'h7cb6,16'h7c79,16'h7c3d,
 16'h7c00,16'h7bc4,16'h7b89,16'h7b4d,16'h7b12,16'h7ad7,16'h7a9c,16'h7a61,16'h7a27,16'h79ec,16'h79b2,16'h7979,16'h793f,16'h7906,16'h78cc,16'h7894,
 16'h785b,16'h7822,16'h77ea,16'h77b2,16'h777a,16'h7742,16'h770b,16'h76d3,16'h769c,16'h7665,16'h762f,16'h75f8,16'h75c2,16'h758c,16'h7556,16'h7520,
 16'h74ea,16'h74b5,16'h7480,16'h744b,16'h7416,16'h73e2,16'h73ad,16'h7379,16'h7345,16'h7311,16'h72dd,16'h72aa,16'h7277,16'h7243,16'h7210,16'h71de,
 16'h71ab,16'h7179,16'h7146,16'h7114,16'h70e2,16'h70b1,16'h707f,16'h704e,16'h701c,16'h6feb,16'h6fba,16'h6f8a,16'h6f59,16'h6f29,16'h6ef9,16'h6ec8,
 16'h6e99,16'h6e69,16'h6e39,16'h6e0a,16'h6ddb,16'h6dab,16'h6d7d,16'h6d4e,16'h6d1f,16'h6cf1,16'h6cc2,16'h6c94,16'h6c66,16'h6c38,16'h6c0a,16'h6bdd,
 16'h6bb0,16'h6b82,16'h6b55,16'h6b28,16'h6afb,16'h6acf,16'h6aa2,16'h6a76,16'h6a49,16'h6a1d,16'h69f1,16'h69c6,16'h699a,16'h696e,16'h6943,16'h6918,
 16'h68ed,16'h68c2,16'h6897,16'h686c,16'h6842,16'h6817,16'h67ed,16'h67c3,16'h6799,16'h676f,16'h6745,16'h671b,16'h66f2,16'h66c8,16'h669f,16'h6676,
 16'h664d,16'h6624,16'h65fc,16'h65d3,16'h65aa,16'h6582,16'h655a,16'h6532,16'h650a,16'h64e2,16'h64ba,16'h6493,16'h646b,16'h6444,16'h641c,16'h63f5,
 16'h63ce,16'h63a7,16'h6381,16'h635a,16'h6333,16'h630d,16'h62e7,16'h62c1,16'h629a,16'h6275,16'h624f,16'h6229,16'h6203,16'h61de,16'h61b8,16'h6193,
 16'h616e,16'h6149,16'h6124,16'h60ff,16'h60da,16'h60b6,16'h6091,16'h606d,16'h6049,16'h6024,16'h6000,16'h5fdc,16'h5fb8,16'h5f95,16'h5f71,16'h5f4d,
 16'h5f2a,16'h5f07,16'h5ee3,16'h5ec0,16'h5e9d,16'h5e7a,16'h5e57,16'h5e35,16'h5e12,16'h5def,16'h5dcd,16'h5dab,16'h5d88,16'h5d66,16'h5d44,16'h5d22,
 16'h5d00,16'h5cde,16'h5cbd,16'h5c9b,16'h5c7a,16'h5c58,16'h5c37,16'h5c16,16'h5bf5,16'h5bd4,16'h5bb3,16'h5b92,16'h5b71,16'h5b51,16'h5b30,16'h5b10,
 16'h5aef,16'h5acf,16'h5aaf,16'h5a8f,16'h5a6f,16'h5a4f,16'h5a2f,16'h5a0f,16'h59ef,16'h59d0,16'h59b0,16'h5991,16'h5972,16'h5952,16'h5933,16'h5914,
 16'h58f5,16'h58d6,16'h58b7,16'h5899,16'h587a,16'h585b,16'h583d,16'h581f,16'h5800,16'h57e2,16'h57c4,16'h57a6,16'h5788,16'h576a,16'h574c,16'h572e,
 16'h5711,16'h56f3,16'h56d5,16'h56b8,16'h569b,16'h567d,16'h5660,16'h5643,16'h5626,16'h5609,16'h55ec,16'h55cf,16'h55b2,16'h5596,16'h5579,16'h555d,
 16'h5540,16'h5524,16'h5507,16'h54eb,16'h54cf,16'h54b3,16'h5497,16'h547b,16'h545f,16'h5443,16'h5428,16'h540c,16'h53f0,16'h53d5,16'h53b9,16'h539e,
 16'h5383,16'h5368,16'h534c,16'h5331,16'h5316,16'h52fb,16'h52e0,16'h52c6,16'h52ab,16'h5290,16'h5276,16'h525b,16'h5240,16'h5226,16'h520c,16'h51f1,
 16'h51d7,16'h51bd,16'h51a3,16'h5189,16'h516f,16'h5155,16'h513b,16'h5121,16'h5108,16'h50ee,16'h50d5,16'h50bb,16'h50a2,16'h5088,16'h506f,16'h5056,
 16'h503c,16'h5023,16'h500a,16'h4ff1,16'h4fd8,16'h4fbf,16'h4fa6,16'h4f8e,16'h4f75,16'h4f5c,16'h4f44,16'h4f2b,16'h4f13,16'h4efa,16'h4ee2,16'h4eca,
 16'h4eb1,16'h4e99,16'h4e81,16'h4e69,16'h4e51,16'h4e39,16'h4e21,16'h4e09,16'h4df1,16'h4dda,16'h4dc2,16'h4daa,16'h4d93,16'h4d7b,16'h4d64,16'h4d4d,
 16'h4d35,16'h4d1e,16'h4d07,16'h4cf0,16'h4cd8,16'h4cc1,16'h4caa,16'h4c93,16'h4c7d,16'h4c66,16'h4c4f,16'h4c38,16'h4c21,16'h4c0b,16'h4bf4,16'h4bde,
 16'h4bc7,16'h4bb1,16'h4b9a,16'h4b84,16'h4b6e,16'h4b58,16'h4b41,16'h4b2b,16'h4b15,16'h4aff,16'h4ae9,16'h4ad3,16'h4abd,16'h4aa8,16'h4a92,16'h4a7c,
 16'h4a66,16'h4a51,16'h4a3b,16'h4a26,16'h4a10,16'h49fb,16'h49e5,16'h49d0,16'h49bb,16'h49a6,16'h4990,16'h497b,16'h4966,16'h4951,16'h493c,16'h4927,
 16'h4912,16'h48fe,16'h48e9,16'h48d4,16'h48bf,16'h48ab,16'h4896,16'h4881,16'h486d,16'h4858,16'h4844,16'h482f,16'h481b,16'h4807,16'h47f3,16'h47de,
 16'h47ca,16'h47b6,16'h47a2,16'h478e,16'h477a,16'h4766,16'h4752,16'h473e,16'h472a,16'h4717,16'h4703,16'h46ef,16'h46db,16'h46c8,16'h46b4,16'h46a1,
 16'h468d,16'h467a,16'h4666,16'h4653,16'h4640,16'h462c,16'h4619,16'h4606,16'h45f3,16'h45e0,16'h45cd,16'h45ba,16'h45a7,16'h4594,16'h4581,16'h456e,
 16'h455b,16'h4548,16'h4536,16'h4523,16'h4510,16'h44fe,16'h44eb,16'h44d8,16'h44c6,16'h44b3,16'h44a1,16'h448f,16'h447c,16'h446a,16'h4458,16'h4445,
 16'h4433,16'h4421,16'h440f,16'h43fd,16'h43eb,16'h43d9,16'h43c7,16'h43b5,16'h43a3,16'h4391,16'h437f,16'h436d,16'h435c,16'h434a,16'h4338,16'h4327,
 16'h4315,16'h4303,16'h42f2,16'h42e0,16'h42cf,16'h42bd,16'h42ac,16'h429b,16'h4289,16'h4278,16'h4267,16'h4256,16'h4244,16'h4233,16'h4222,16'h4211,
 16'h4200,16'h41ef,16'h41de,16'h41cd,16'h41bc,16'h41ab,16'h419a,16'h418a,16'h4179,16'h4168,16'h4157,16'h4147,16'h4136,16'h4125,16'h4115,16'h4104,
 16'h40f4,16'h40e3,16'h40d3,16'h40c2,16'h40b2,16'h40a2,16'h4091,16'h4081,16'h4071,16'h4061,16'h4050,16'h4040,16'h4030,16'h4020,16'h4010,16'h4000
        };
        return tab[idx];
    endfunction

    // Leading-zero count of a nonzero 32-bit word.
    function automatic logic [4:0] count_lz(input word_t x);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && x[i]) begin
                found = 1'b1;
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ hdl/fpd_stage.sv @@
// One pipeline stage of the divider: a register slot with a valid bit and stall control.
`default_nettype none
module fpd_stage
    import fpd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire stage_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output stage_t      out_data
);

    logic   valid_reg;
    stage_t data_reg;

    // The slot takes new data when empty or when its contents leave this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/fixed_point_divide_16_16.sv @@
// Top level of the pipelined signed 16.16 fixed-point divider.
// Usage: one transaction on the s_ channel carries dividend (tdata bits 31:0) and divisor
// (tdata bits 63:32), both signed 16.16. One transaction on the m_ channel returns the
// signed 16.16 quotient in tdata bits 31:0 and the saturation flag in tuser.
// When the dividend's magnitude shifted right by 14 reaches the divisor's magnitude
// (a zero divisor included), the quotient is the signed extreme and tuser is 1.
// Otherwise the magnitude quotient comes from a table-seeded reciprocal with two
// refinement steps and a single downward correction, so it may be one below exact.
// There are eight
// register stages, the first of which captures the transaction at its accepting edge,
// and each stage holds at most one 32-by-32 multiply.
// Throughput is one transaction per cycle; a new input is taken every cycle while
// the output side accepts.
// When the receiver holds m_axis_tready low, the pipeline fills its empty slots and then
// stalls as a whole; no transaction is lost or repeated.
// A synchronous active-low reset empties every stage; the data registers keep their
// contents but are marked invalid.
`default_nettype none
module fixed_point_divide_16_16
    import fpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // dividend [31:0], divisor [63:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // quotient [31:0]
    output logic             m_axis_tuser   // saturated
);

    stage_t dat_in  [NStages];
    stage_t dat_out [NStages];
    logic   vin  [NStages];
    logic   rdy  [NStages];
    logic   vout [NStages];
    logic   rout [NStages];

    genvar g;
    generate
        for (g = 0; g < NStages; g++) begin : g_stage
            fpd_stage u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (vin[g]),
                .in_ready  (rdy[g]),
                .in_data   (dat_in[g]),
                .out_valid (vout[g]),
                .out_ready (rout[g]),
                .out_data  (dat_out[g])
            );
            if (g > 0) begin : g_link
                assign vin[g]    = vout[g-1];
                assign rout[g-1] = rdy[g];
            end
        end
    endgenerate

    assign vin[0]          = s_axis_tvalid;
    assign s_axis_tready   = rdy[0];
    assign rout[NStages-1] = m_axis_tready;
    assign m_axis_tvalid   = vout[NStages-1];
    assign m_axis_tdata    = dat_out[NStages-1].c;
    assign m_axis_tuser    = dat_out[NStages-1].sat;

    // Stage 0: magnitudes, overflow guard, leading-zero count.
    word_t in_a, in_b, ma, mb;
    always_comb begin
        in_a = s_axis_tdata[31:0];
        in_b = s_axis_tdata[63:32];
        ma = in_a[31] ? (32'd0 - in_a) : in_a;
        mb = in_b[31] ? (32'd0 - in_b) : in_b;
        dat_in[0] = '0;
        dat_in[0].neg = in_a[31] ^ in_b[31];
        dat_in[0].sat = ({14'd0, ma[31:14]} >= mb);
        dat_in[0].sh  = count_lz(mb);
        dat_in[0].a   = ma;
        dat_in[0].b   = mb;
    end

    // Stage 1: normalize operands, fetch seed, form s0*s0.
    // The shifted numerator can reach far above bit 47, so it is kept in 64 bits.
    stage_t p0;
    logic [63:0] num1;
    logic [15:0] s0;
    always_comb begin
        p0 = dat_out[0];
        dat_in[1] = p0;
        num1 = {16'd0, p0.a, 16'd0} << p0.sh;
        dat_in[1].d  = p0.b << p0.sh;
        dat_in[1].n1 = num1[63:32];
        dat_in[1].n0 = num1[31:0];
        s0 = seed_lookup(dat_in[1].d[30:22]);
        dat_in[1].a = {16'd0, s0};
        dat_in[1].b = 32'({16'd0, s0} * {16'd0, s0});
    end

    // Stage 2: s1 = (s0 << 4) - hi(s0*s0 * mid) - 1.
    stage_t p1;
    logic [63:0] m2;
    always_comb begin
        p1 = dat_out[1];
        dat_in[2] = p1;
        m2 = p1.b * ({11'd0, p1.d[31:11]} + 32'd1);
        dat_in[2].a = (p1.a << 4) - m2[63:32] - 32'd1;
    end

    // Stage 3: err = -s1*half (+ s1>>1 when d is odd).
    stage_t p2;
    word_t err3;
    always_comb begin
        p2 = dat_out[2];
        dat_in[3] = p2;
        err3 = 32'd0 - 32'(p2.a * {1'b0, p2.d[31:1]});
        if (p2.d[0]) begin
            err3 = err3 + {1'b0, p2.a[31:1]};
        end
        dat_in[3].b = err3;
    end

    // Stage 4: s2 = (s1 << 15) + (hi(s1*err) >> 1).
    stage_t p3;
    logic [63:0] m4;
    always_comb begin
        p3 = dat_out[3];
        dat_in[4] = p3;
        m4 = p3.a * p3.b;
        dat_in[4].a = (p3.a << 15) + {1'b0, m4[63:33]};
    end

    // Stage 5: v = s2 - (hi(s2*d) + d + carry(lo + d)).
    stage_t p4;
    logic [63:0] m5;
    logic [32:0] lo_sum;
    always_comb begin
        p4 = dat_out[4];
        dat_in[5] = p4;
        m5 = p4.a * p4.d;
        lo_sum = {1'b0, m5[31:0]} + {1'b0, p4.d};
        dat_in[5].v = p4.a - (m5[63:32] + p4.d + {31'd0, lo_sum[32]});
    end

    // Stage 6: p = v*n1, plo and qhi.
    stage_t p5;
    logic [63:0] m6;
    logic [32:0] plo_sum;
    always_comb begin
        p5 = dat_out[5];
        dat_in[6] = p5;
        m6 = p5.v * p5.n1;
        plo_sum = {1'b0, m6[31:0]} + {1'b0, p5.n0};
        dat_in[6].b = plo_sum[31:0];
        dat_in[6].a = m6[63:32] + p5.n1 + {31'd0, plo_sum[32]} + 32'd1;
    end

    // Stage 7: remainder check, one downward correction, sign and saturation.
    stage_t p6;
    word_t rem7, q7;
    always_comb begin
        p6 = dat_out[6];
        dat_in[7] = p6;
        rem7 = p6.n0 - 32'(p6.a * p6.d);
        q7 = (rem7 > p6.b) ? (p6.a - 32'd1) : p6.a;
        if (p6.sat) begin
            dat_in[7].c = p6.neg ? SatNeg : SatPos;
        end else begin
            dat_in[7].c = p6.neg ? (32'd0 - q7) : q7;
        end
    end

    // A saturated result is always one of the two extremes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata == SatNeg || m_axis_tdata == SatPos))
        else $error("saturated result is not an extreme value");

    // A stalled output keeps its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

    // While the output is not blocked, the input side is ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("pipeline stalled without backpressure");

endmodule
`default_nettype wire

@@ tb/sv/fixed_point_divide_16_16_tb.sv @@
// Testbench for the signed 16.16 fixed-point divider: random and directed operands, scoreboard check.
`default_nettype none
module fixed_point_divide_16_16_tb
    import fpd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected quotient and saturation flag for one transaction.
    typedef struct packed {
        logic [31:0] quotient;
        logic        saturated;
    } quot_t;

    // Upper 32 bits of an unsigned 32-by-32 product.
    function automatic logic [31:0] prod_hi(logic [31:0] x, logic [31:0] y);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        return p[63:32];
    endfunction

    // Reciprocal of a normalized divisor, seeded from the package table.
    function automatic logic [31:0] reciprocal(logic [31:0] d);
        logic [31:0] s0, s1, s2, err, mid, lo, hi, sum;
        logic [63:0] p;
        s0 = {16'd0, seed_lookup(d[30:22])};
        mid = (d >> 11) + 32'd1;
        s1 = (s0 << 4) - prod_hi(s0 * s0, mid) - 32'd1;
        err = 32'd0 - s1 * (d >> 1);
        if (d[0]) begin
            err = err + (s1 >> 1);
        end
        s2 = (s1 << 15) + (prod_hi(s1, err) >> 1);
        p = {32'd0, s2} * {32'd0, d};
        lo = p[31:0];
        hi = p[63:32];
        sum = lo + d;
        return s2 - (hi + d + {31'd0, (sum < lo)});
    endfunction

    // Predicted divider output for one dividend/divisor pair.
    function automatic quot_t divide_expect(logic [31:0] a, logic [31:0] b);
        quot_t r;
        logic neg;
        logic [31:0] ma, mb, n0, n1, d, v, plo, qhi, rem;
        logic [63:0] p;
        int sh;
        neg = a[31] ^ b[31];
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if ((ma >> 14) >= mb) begin
            r.quotient = neg ? SatNeg : SatPos;
            r.saturated = 1'b1;
            return r;
        end
        sh = 0;
        while (sh < 31 && !mb[31 - sh]) sh++;
        n0 = ma << 16;
        n1 = ma >> 16;
        d = mb << sh;
        v = reciprocal(d);
        if (sh != 0) begin
            n1 = (n1 << sh) | (n0 >> (32 - sh));
            n0 = n0 << sh;
        end
        p = {32'd0, v} * {32'd0, n1};
        plo = p[31:0] + n0;
        qhi = p[63:32] + n1 + {31'd0, (plo < n0)} + 32'd1;
        rem = n0 - qhi * d;
        if (rem > plo) begin
            qhi = qhi - 32'd1;
        end
        r.quotient = neg ? -qhi : qhi;
        r.saturated = 1'b0;
        return r;
    endfunction

    // Scoreboard that holds predicted quotients in order of acceptance.
    class quot_board;
        quot_t pending[$];
        int    mismatches = 0;

        function void note_input(logic [31:0] a, logic [31:0] b);
            pending.push_back(divide_expect(a, b));
        endfunction

        function void check_result(logic [31:0] q, logic s);
            quot_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result q=%h sat=%b", q, s);
                return;
            end
            e = pending.pop_front();
            if (e.quotient !== q || e.saturated !== s) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected q=%h sat=%b, got q=%h sat=%b",
                             e.quotient, e.saturated, q, s);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    quot_board board = new();
    bit        long_hold = 1'b0;   // Requests a long receiver stall.
    bit        stim_done = 1'b0;

    always #5 aclk = ~aclk;

    fixed_point_divide_16_16 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // dividend [31:0], divisor [63:32]
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // quotient [31:0]
        .m_axis_tuser(m_axis_tuser)    // saturated
    );

    // Every accepted output transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // The receiver stalls on its own pattern: mostly ready, occasional short stalls,
    // stretches with no stall at all, and one long hold-off when requested.
    initial begin : receiver
        int mode, k;
        mode = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                for (k = 0; k < 60; k++) @(posedge aclk);
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 9);
            for (k = 0; k < $urandom_range(1, 20); k++) begin
                m_axis_tready <= (mode < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
                @(posedge aclk);
            end
        end
    end

    // Offers one transaction and holds it until the block takes it.
    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_input(a, b);
    endtask

    // Sender idles for a random gap; zero keeps tvalid high across items.
    task automatic sender_gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Random operand with a spread of magnitudes so both paths are reached.
    function automatic logic [31:0] rand_operand();
        logic [31:0] x;
        x = $urandom();
        case ($urandom_range(0, 4))
            0: x = x >> $urandom_range(0, 31);
            1: x = $signed(x) >>> $urandom_range(0, 31);
            2: x = {x[31], {31{~x[31]}}};
            default: ;
        endcase
        return x;
    endfunction

    initial begin : stimulus
        logic [31:0] directed_a[$];
        logic [31:0] directed_b[$];
        logic [31:0] a, b;
        int i, burst;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, zero divisor, zero dividend, guard boundary and sign mixes.
        directed_a = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000,
                       32'h0001_0000, 32'h0003_ffff, 32'h0004_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
                       32'h1234_5678, 32'hedcb_a988, 32'h0000_4000, 32'h0001_0000};
        directed_b = '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'hffff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
                       32'hffff_0000, 32'h0000_000f, 32'h0000_0011, 32'h0000_2001,
                       32'h0000_2001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                       32'h0003_0000, 32'hfffd_0000, 32'h0000_0002, 32'h0000_0003};
        foreach (directed_a[j]) send_pair(directed_a[j], directed_b[j]);
        sender_gap(1);

        // Pause until every prediction has been matched.
        while (board.pending.size() != 0) @(posedge aclk);

        // Long receiver hold-off while the sender keeps offering back to back.
        long_hold = 1'b1;
        for (i = 0; i < 40; i++) send_pair(rand_operand(), rand_operand());

        // Random bursts separated by random gaps.
        i = 0;
        while (i < 340) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                a = rand_operand();
                b = rand_operand();
                send_pair(a, b);
                i++;
            end
            sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/fpd_pkg.sv
hdl/fpd_stage.sv
hdl/fixed_point_divide_16_16.sv
tb/sv/fixed_point_divide_16_16_tb.sv
